/* rtl/core/matrix_keypad_scanner_core_assert.svh */
// Assertion macros shared by the keypad scanner RTL.
`ifndef MATRIX_KEYPAD_SCANNER_CORE_ASSERT_SVH
`define MATRIX_KEYPAD_SCANNER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MKS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad scanner assertion failed");

// Next-cycle implication, checked outside reset.
`define MKS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad scanner assertion failed");

`endif

/* rtl/core/mks_pkg.sv */
// Package with the types, constants and key table of the keypad scanner.
package mks_pkg;

  localparam int unsigned NUM_COLUMNS_DEFAULT = 5;
  localparam int unsigned ROW_COUNT = 5;
  localparam int unsigned TABLE_COLUMNS = 5;
  localparam int unsigned COLUMN_WIDTH = 3;
  localparam int unsigned CODE_WIDTH = 8;
  localparam int unsigned DIVIDER_WIDTH = 8;
  localparam int unsigned APB_ADDR_WIDTH = 2;
  localparam int unsigned APB_DATA_WIDTH = 32;

  localparam logic [DIVIDER_WIDTH-1:0] DEBOUNCE_RESET = 8'd30;
  localparam logic [ROW_COUNT-1:0] ALL_ROWS_HIGH = 5'h1F;
  localparam logic [APB_ADDR_WIDTH-1:0] REG_DEBOUNCE_ADDR = 2'd0;

  typedef logic [COLUMN_WIDTH-1:0] column_t;
  typedef logic [CODE_WIDTH-1:0] code_t;
  typedef logic [ROW_COUNT-1:0] rows_t;
  typedef logic [2:0] row_idx_t;

  typedef struct packed {
    column_t column_drive;
    code_t   key_code;
    logic    key_released;
  } result_t;

  // Rows top to bottom, columns left to right.
  localparam code_t KEY_MAP [ROW_COUNT][TABLE_COLUMNS] = '{
    '{8'h3C, 8'h52, 8'h3E, 8'h44, 8'h4C},
    '{8'h31, 8'h33, 8'h36, 8'h55, 8'h32},
    '{8'h34, 8'h36, 8'h39, 8'h4F, 8'h35},
    '{8'h37, 8'h39, 8'h23, 8'h47, 8'h38},
    '{8'h2A, 8'h23, 8'h4B, 8'h4D, 8'h30}
  };

  function automatic row_idx_t lowest_low_row(rows_t levels);
    row_idx_t r;
    r = '0;
    for (int i = ROW_COUNT - 1; i >= 0; i--) begin
      if (!levels[i]) begin
        r = row_idx_t'(i);
      end
    end
    return r;
  endfunction

  function automatic code_t key_lookup(row_idx_t row, column_t col);
    code_t c;
    c = '0;
    if (32'(row) < ROW_COUNT && 32'(col) < TABLE_COLUMNS) begin
      c = KEY_MAP[row][col];
    end
    return c;
  endfunction

endpackage

/* rtl/core/mks_apb_regs.sv */
// APB register block holding the debounce divider.
module mks_apb_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [mks_pkg::APB_ADDR_WIDTH-1:0]    paddr,
  input  logic [mks_pkg::APB_DATA_WIDTH-1:0]    pwdata,
  output logic [mks_pkg::APB_DATA_WIDTH-1:0]    prdata,
  output logic                                  pready,
  output logic [mks_pkg::DIVIDER_WIDTH-1:0]     debounce_divider
);
  import mks_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == REG_DEBOUNCE_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_divider <= DEBOUNCE_RESET;
    end else if (wr_en) begin
      debounce_divider <= pwdata[DIVIDER_WIDTH-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_DEBOUNCE_ADDR) begin
      prdata = APB_DATA_WIDTH'(debounce_divider);
    end
  end

endmodule

/* rtl/core/mks_scan.sv */
// Scan state registers and the per-tick step logic of the keypad scanner.
module mks_scan #(
  parameter int unsigned NUM_COLUMNS = mks_pkg::NUM_COLUMNS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [mks_pkg::ROW_COUNT-1:0]     levels,
  input  logic [mks_pkg::DIVIDER_WIDTH-1:0] debounce_divider,
  output mks_pkg::result_t                  result
);
  import mks_pkg::*;

  logic [DIVIDER_WIDTH-1:0] tick_counter, tick_counter_next;
  column_t                  column_index, column_index_next;
  logic                     key_held, key_held_next;
  code_t                    held_key_code, held_key_code_next;

  logic [DIVIDER_WIDTH-1:0] tick_inc;
  logic [COLUMN_WIDTH:0]    column_inc;
  logic                     scan_tick;
  logic                     all_high;

  assign tick_inc   = tick_counter + 1'b1;
  assign scan_tick  = tick_inc > debounce_divider;
  assign all_high   = (levels == ALL_ROWS_HIGH);
  assign column_inc = {1'b0, column_index} + 1'b1;

  always_comb begin
    tick_counter_next  = tick_inc;
    column_index_next  = column_index;
    key_held_next      = key_held;
    held_key_code_next = held_key_code;
    result.key_code     = '0;
    result.key_released = 1'b0;
    if (scan_tick) begin
      tick_counter_next = '0;
      if (key_held) begin
        if (all_high) begin
          result.key_code     = held_key_code;
          result.key_released = 1'b1;
          key_held_next       = 1'b0;
          held_key_code_next  = '0;
        end
      end else if (!all_high) begin
        held_key_code_next = key_lookup(lowest_low_row(levels), column_index);
        key_held_next      = 1'b1;
      end else if (32'(column_inc) >= NUM_COLUMNS) begin
        column_index_next = '0;
      end else begin
        column_index_next = column_inc[COLUMN_WIDTH-1:0];
      end
    end
    result.column_drive = column_index_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter  <= '0;
      column_index  <= '0;
      key_held      <= 1'b0;
      held_key_code <= '0;
    end else if (step) begin
      tick_counter  <= tick_counter_next;
      column_index  <= column_index_next;
      key_held      <= key_held_next;
      held_key_code <= held_key_code_next;
    end
  end

endmodule

/* rtl/core/matrix_keypad_scanner_core.sv */
// Top level of the 5-row matrix keypad scanner with its transfer stages.
//
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   row_levels
// out      output     out_valid/out_stall column_drive, key_code, key_released
// cfg      input      APB psel/penable    debounce_divider at byte address 0
//
// One tick is taken every clock while a transfer is held and the output is free.
// The input register feeds the scan step, which writes the result register.
// Synchronous reset clears valid flags and scan state; the divider returns to 30.
// A stall on the output holds the result and, once the input register is full,
// raises the input stall in the same cycle.
module matrix_keypad_scanner_core #(
  parameter int unsigned NUM_COLUMNS = mks_pkg::NUM_COLUMNS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [mks_pkg::ROW_COUNT-1:0]      row_levels,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [mks_pkg::COLUMN_WIDTH-1:0]   column_drive,
  output logic [mks_pkg::CODE_WIDTH-1:0]     key_code,
  output logic                               key_released,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mks_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input  logic [mks_pkg::APB_DATA_WIDTH-1:0] pwdata,
  output logic [mks_pkg::APB_DATA_WIDTH-1:0] prdata,
  output logic                               pready
);
  import mks_pkg::*;

  logic                     in_reg_valid;
  rows_t                    in_reg_levels;
  logic                     out_free;
  logic                     advance;
  logic [DIVIDER_WIDTH-1:0] debounce_divider;
  result_t                  step_result;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_reg_valid && out_free;
  assign in_stall = in_reg_valid && !out_free;

  mks_apb_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .debounce_divider (debounce_divider)
  );

  mks_scan #(
    .NUM_COLUMNS (NUM_COLUMNS)
  ) u_scan (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .levels           (in_reg_levels),
    .debounce_divider (debounce_divider),
    .result           (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_levels <= row_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      column_drive <= step_result.column_drive;
      key_code     <= step_result.key_code;
      key_released <= step_result.key_released;
    end
  end

`include "matrix_keypad_scanner_core_assert.svh"

  `MKS_ASSERT_IMPL(a_idle_code_zero, clk, rst, out_valid && !key_released, key_code == '0)
  `MKS_ASSERT_IMPL(a_column_range, clk, rst, out_valid, 32'(column_drive) < NUM_COLUMNS)
  `MKS_ASSERT_NEXT(a_advance_fills_output, clk, rst, advance, out_valid)
  `MKS_ASSERT_IMPL(a_stall_when_full, clk, rst, in_stall, in_reg_valid && out_valid && out_stall)

endmodule
